// ===== hw/rtl/fsd_pkg.sv =====
package fsd_pkg;

   localparam int FRAME_WIDTH  = 640;
   localparam int FRAME_HEIGHT = 480;
   localparam int PIX_TOTAL    = FRAME_WIDTH * FRAME_HEIGHT;

   // address into the pixel store, and a count that can also hold the total
   localparam int ADDR_W = (PIX_TOTAL > 1) ? $clog2(PIX_TOTAL) : 1;
   localparam int CNT_W  = $clog2(PIX_TOTAL + 1);

   localparam int ACC_W   = 19;
   localparam int STILL_W = 8;
   localparam int MODE_W  = 2;

   localparam logic [ACC_W-1:0] ACC_MAX      = {ACC_W{1'b1}};
   localparam logic [ACC_W-1:0] THRESH_RESET = ACC_W'(900);

   localparam logic signed [STILL_W-1:0] COUNTER_TOP    = STILL_W'(127);
   localparam logic signed [STILL_W-1:0] TRIGGER_NORMAL = STILL_W'(4);
   localparam logic signed [STILL_W-1:0] TRIGGER_BOOT   = STILL_W'(2);
   localparam logic signed [STILL_W-1:0] RELOAD_LEARN   = -STILL_W'(5);
   localparam logic signed [STILL_W-1:0] RELOAD_PLAY    = -STILL_W'(10);
   localparam logic signed [STILL_W-1:0] RELOAD_BOOT    = '0;
   // lowest count a result can show without an action (one step above play reload)
   localparam logic signed [STILL_W-1:0] STILL_IDLE_MIN = -STILL_W'(9);
   localparam logic signed [STILL_W-1:0] STILL_IDLE_MAX = STILL_W'(3);

   localparam logic [MODE_W-1:0] MODE_LEARN = MODE_W'(1);
   localparam logic [MODE_W-1:0] MODE_BOOT  = MODE_W'(3);

   typedef enum logic [1:0] {
      ACT_NONE     = 2'd0,
      ACT_LEARN    = 2'd1,
      ACT_CLASSIFY = 2'd2,
      ACT_BOOT     = 2'd3
   } action_type;

   // register file: one word per register, selected by one address bit
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_SEL_BIT = 2;
   localparam logic REG_RUN_MODE       = 1'b0;
   localparam logic REG_DIFF_THRESHOLD = 1'b1;

   typedef struct packed {
      logic [MODE_W-1:0] run_mode;
      logic [ACC_W-1:0]  diff_threshold;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic diff;
      logic last;
   } pix_stage_type;

endpackage

// ===== hw/rtl/fsd_csr.sv =====
module fsd_csr import fsd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [MODE_W-1:0] run_mode_ff, run_mode_in;
   logic [ACC_W-1:0]  diff_threshold_ff, diff_threshold_in;
   logic              wr_en;
   logic              reg_sel;

   assign wr_en   = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel = csr_paddr[CSR_SEL_BIT];

   always_comb begin
      run_mode_in       = run_mode_ff;
      diff_threshold_in = diff_threshold_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_RUN_MODE:       run_mode_in       = csr_pwdata[MODE_W-1:0];
            REG_DIFF_THRESHOLD: diff_threshold_in = csr_pwdata[ACC_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_mode_ff       <= '0;
         diff_threshold_ff <= THRESH_RESET;
      end else begin
         run_mode_ff       <= run_mode_in;
         diff_threshold_ff <= diff_threshold_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_RUN_MODE:       csr_prdata = CSR_DATA_W'(run_mode_ff);
         REG_DIFF_THRESHOLD: csr_prdata = CSR_DATA_W'(diff_threshold_ff);
         default:            csr_prdata = '0;
      endcase
   end

   assign csr_pready         = 1'b1;
   assign cfg.run_mode       = run_mode_ff;
   assign cfg.diff_threshold = diff_threshold_ff;

endmodule

// ===== hw/rtl/fsd_pixel_store.sv =====
module fsd_pixel_store import fsd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  logic          pixel_on,
   input  logic          frame_end,
   input  logic          advance,
   output pix_stage_type stage
);

   logic mem [PIX_TOTAL];

   logic [CNT_W-1:0] idx_ff, idx_in;
   // every position below this mark has been written since reset
   logic [CNT_W-1:0] seen_ff, seen_in;
   logic             valid_ff, valid_in;
   logic             pix_ff, old_ff, hit_ff, known_ff, last_ff;
   logic             in_range;
   logic [ADDR_W-1:0] addr;

   assign in_range = idx_ff < CNT_W'(PIX_TOTAL);
   assign addr     = idx_ff[ADDR_W-1:0];

   // read-before-write at the same address in the same cycle
   always_ff @(posedge clock) begin
      if (load && in_range) begin
         old_ff    <= mem[addr];
         mem[addr] <= pixel_on;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pix_ff   <= pixel_on;
         hit_ff   <= in_range;
         known_ff <= idx_ff < seen_ff;
         last_ff  <= frame_end;
      end
   end

   always_comb begin
      idx_in   = idx_ff;
      seen_in  = seen_ff;
      valid_in = valid_ff;
      if (advance) valid_in = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         if (frame_end) begin
            idx_in = '0;
         end else if (in_range) begin
            idx_in = idx_ff + CNT_W'(1);
         end
         if (in_range && (idx_ff == seen_ff)) seen_in = seen_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         seen_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         seen_ff  <= seen_in;
         valid_ff <= valid_in;
      end
   end

   // never-written positions read as black
   assign stage.valid = valid_ff;
   assign stage.diff  = hit_ff & (pix_ff ^ (old_ff & known_ff));
   assign stage.last  = last_ff;

endmodule

// ===== hw/rtl/fsd_frame_eval.sv =====
module fsd_frame_eval import fsd_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  pix_stage_type               stage,
   input  cfg_type                     cfg,
   output logic                        advance,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_action,
   output logic [ACC_W-1:0]            rsp_diff_count,
   output logic signed [STILL_W-1:0]   rsp_still_count
);

   logic [ACC_W-1:0]          acc_ff, acc_in, acc_sum;
   logic signed [STILL_W-1:0] still_ff, still_in, still_bumped, still_new;
   logic                      rsp_valid_ff, rsp_valid_in;
   action_type                action_new, rsp_action_ff;
   logic [ACC_W-1:0]          rsp_diff_ff;
   logic signed [STILL_W-1:0] rsp_still_ff;
   logic                      out_free;
   logic                      fire_last;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = stage.valid && (!stage.last || out_free);
   assign fire_last = advance && stage.last;

   assign acc_sum = (stage.diff && (acc_ff != ACC_MAX)) ? acc_ff + ACC_W'(1) : acc_ff;

   always_comb begin
      if (acc_sum < cfg.diff_threshold) begin
         still_bumped = (still_ff < COUNTER_TOP) ? still_ff + STILL_W'(1) : still_ff;
      end else begin
         still_bumped = '0;
      end
   end

   always_comb begin
      action_new = ACT_NONE;
      still_new  = still_bumped;
      case (cfg.run_mode)
         MODE_LEARN: begin
            if (still_bumped >= TRIGGER_NORMAL) begin
               action_new = ACT_LEARN;
               still_new  = RELOAD_LEARN;
            end
         end
         MODE_BOOT: begin
            if (still_bumped >= TRIGGER_BOOT) begin
               action_new = ACT_BOOT;
               still_new  = RELOAD_BOOT;
            end
         end
         default: begin
            if (still_bumped >= TRIGGER_NORMAL) begin
               action_new = ACT_CLASSIFY;
               still_new  = RELOAD_PLAY;
            end
         end
      endcase
   end

   always_comb begin
      acc_in       = acc_ff;
      still_in     = still_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (advance) begin
         acc_in = stage.last ? '0 : acc_sum;
      end
      if (fire_last) begin
         still_in     = still_new;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         still_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         still_ff     <= still_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire_last) begin
         rsp_action_ff <= action_new;
         rsp_diff_ff   <= acc_sum;
         rsp_still_ff  <= still_new;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_action      = rsp_action_ff;
   assign rsp_diff_count  = rsp_diff_ff;
   assign rsp_still_count = rsp_still_ff;

endmodule

// ===== hw/rtl/frame_stillness_detector.sv =====
// channel   direction  transfer when        payload
// req       in         req_valid&req_ready  pixel_on, frame_end
// rsp       out        rsp_valid&rsp_ready  action, diff_count, still_count
// csr       in/out     psel&penable         run_mode @0x0, diff_threshold @0x4
//
// one pixel per clock sustained while no stalled result holds a frame-end pixel; a frame-end
// result passes the store read stage, then the result register, before it is valid
// the per-pixel rate is set by the single read-before-write port of the pixel store
// reset clears counters, config and the written-position mark at once; unwritten
// store positions read as black, so no clearing pass runs
// a stalled result holds back the next frame-end pixel once it reaches the store read stage, and all later pixels
module frame_stillness_detector import fsd_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_pixel_on,
   input  logic                       req_frame_end,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_action,
   output logic [ACC_W-1:0]           rsp_diff_count,
   output logic signed [STILL_W-1:0]  rsp_still_count,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [CSR_DATA_W-1:0]      csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   cfg_type       cfg;
   pix_stage_type stage;
   logic          advance;
   logic          load;

   assign req_ready = !reset && (!stage.valid || advance);
   assign load      = req_valid && req_ready;

   fsd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   fsd_pixel_store u_store (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .pixel_on  (req_pixel_on),
      .frame_end (req_frame_end),
      .advance   (advance),
      .stage     (stage)
   );

   fsd_frame_eval u_eval (
      .clock           (clock),
      .reset           (reset),
      .stage           (stage),
      .cfg             (cfg),
      .advance         (advance),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_action      (rsp_action),
      .rsp_diff_count  (rsp_diff_count),
      .rsp_still_count (rsp_still_count)
   );

endmodule

// ===== hw/rtl/fsd_checker.sv =====
module fsd_checker import fsd_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       req_frame_end,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [1:0]                 rsp_action,
   input logic [ACC_W-1:0]           rsp_diff_count,
   input logic signed [STILL_W-1:0]  rsp_still_count
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_action)
         && $stable(rsp_diff_count) && $stable(rsp_still_count))
      else $error("result changed while stalled");

   // a fresh result comes from an earlier frame-end pixel transfer
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_frame_end, 2))
      else $error("result without a frame-end transfer");

   // each action reports its reload value
   a_reload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_action != ACT_LEARN || rsp_still_count == RELOAD_LEARN)
         && (rsp_action != ACT_CLASSIFY || rsp_still_count == RELOAD_PLAY)
         && (rsp_action != ACT_BOOT || rsp_still_count == RELOAD_BOOT))
      else $error("action with wrong reload value");

   // without an action the counter stays within STILL_IDLE_MIN to STILL_IDLE_MAX, below the normal trigger
   a_idle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == ACT_NONE |->
         rsp_still_count >= STILL_IDLE_MIN && rsp_still_count <= STILL_IDLE_MAX)
      else $error("stillness count out of range without action");

endmodule

bind frame_stillness_detector fsd_checker u_fsd_checker (.*);

// ===== test/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import fsd_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 1_500_000;
   localparam int unsigned HOLD_CYCLES   = 400;
   localparam int unsigned SETTLE_CYCLES = 6;
   localparam int unsigned RANDOM_PHASES = 8;
   localparam int unsigned PHASE_PIXELS  = 190;

   localparam logic [CSR_ADDR_W-1:0] ADDR_RUN_MODE =
      CSR_ADDR_W'(REG_RUN_MODE) << CSR_SEL_BIT;
   localparam logic [CSR_ADDR_W-1:0] ADDR_THRESH =
      CSR_ADDR_W'(REG_DIFF_THRESHOLD) << CSR_SEL_BIT;

   localparam logic [MODE_W-1:0] MODE_PLAY     = MODE_W'(0);
   localparam logic [MODE_W-1:0] MODE_PLAY_ALT = MODE_W'(2);

   typedef struct {
      action_type                action;
      logic [ACC_W-1:0]          diff_count;
      logic signed [STILL_W-1:0] still_count;
   } frame_result_type;

   typedef enum {FRAME_SAME, FRAME_FLIPS, FRAME_NOISE, FRAME_WHITE, FRAME_BLACK} frame_kind_type;
   typedef enum {SINK_ALWAYS, SINK_RANDOM, SINK_PERIODIC} sink_style_type;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_pixel_on = 1'b0;
   logic                      req_frame_end = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [1:0]                rsp_action;
   logic [ACC_W-1:0]          rsp_diff_count;
   logic signed [STILL_W-1:0] rsp_still_count;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]     csr_paddr = '0;
   logic [CSR_DATA_W-1:0]     csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]     csr_prdata;
   logic                      csr_pready;

   frame_stillness_detector i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_on    (req_pixel_on),
      .req_frame_end   (req_frame_end),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_action      (rsp_action),
      .rsp_diff_count  (rsp_diff_count),
      .rsp_still_count (rsp_still_count),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   // frame model: last frame's pixels, running count, stillness counter, config
   bit                        prev_frame [PIX_TOTAL];
   int unsigned               pix_idx = 0;
   logic [ACC_W-1:0]          diff_acc = '0;
   logic signed [STILL_W-1:0] still_ctr = '0;
   logic [MODE_W-1:0]         cfg_mode = '0;
   logic [ACC_W-1:0]          cfg_thresh = THRESH_RESET;
   frame_result_type          pending_frames [$];

   int unsigned fail_count = 0;
   int unsigned frames_checked = 0;
   int unsigned pixels_sent = 0;
   int unsigned csr_writes = 0;
   int unsigned action_hits [4];
   int unsigned cycle_count = 0;

   bit             gaps_on = 1'b1;
   int unsigned    burst_left = 0;
   sink_style_type sink_style = SINK_ALWAYS;
   int unsigned    sink_stall_pct = 30;
   int unsigned    sink_step = 0;
   int unsigned    held = 0;
   logic           hold_request = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d frames outstanding",
                  cycle_count, pending_frames.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // result receiver: long hold-off on request, otherwise its own stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_request) begin
         rsp_ready <= 1'b0;
         held++;
         if (held >= HOLD_CYCLES) begin
            hold_request <= 1'b0;
            held = 0;
         end
      end else begin
         sink_step++;
         case (sink_style)
            SINK_ALWAYS: begin
               rsp_ready <= 1'b1;
            end
            SINK_RANDOM: begin
               rsp_ready <= $urandom_range(99) >= sink_stall_pct;
            end
            default: begin
               rsp_ready <= (sink_step % 7) < 4;
            end
         endcase
      end
   end

   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_frames.size() == 0) begin
            $error("unexpected result: action %0d diff_count %0d still_count %0d",
                   rsp_action, rsp_diff_count, rsp_still_count);
            fail_count++;
         end else begin
            want = pending_frames.pop_front();
            frames_checked++;
            if (rsp_action !== want.action) begin
               $error("action: expected %0d, got %0d", want.action, rsp_action);
               fail_count++;
            end
            if (rsp_diff_count !== want.diff_count) begin
               $error("diff_count: expected %0d, got %0d", want.diff_count, rsp_diff_count);
               fail_count++;
            end
            if (rsp_still_count !== want.still_count) begin
               $error("still_count: expected %0d, got %0d",
                      want.still_count, rsp_still_count);
               fail_count++;
            end
         end
      end
   end

   // one accepted pixel: compare with the stored frame, close the frame on frame_end
   function automatic void score_pixel(input bit pix, input bit last);
      frame_result_type res;
      if (pix_idx < PIX_TOTAL) begin
         if ((prev_frame[pix_idx] ^ pix) && diff_acc != ACC_MAX)
            diff_acc++;
         prev_frame[pix_idx] = pix;
         pix_idx++;
      end
      if (last) begin
         if (diff_acc < cfg_thresh) begin
            if (still_ctr < COUNTER_TOP)
               still_ctr++;
         end else begin
            still_ctr = '0;
         end
         res.action = ACT_NONE;
         if (cfg_mode == MODE_LEARN) begin
            if (still_ctr >= TRIGGER_NORMAL) begin
               res.action = ACT_LEARN;
               still_ctr = RELOAD_LEARN;
            end
         end else if (cfg_mode == MODE_BOOT) begin
            if (still_ctr >= TRIGGER_BOOT) begin
               res.action = ACT_BOOT;
               still_ctr = RELOAD_BOOT;
            end
         end else if (still_ctr >= TRIGGER_NORMAL) begin
            res.action = ACT_CLASSIFY;
            still_ctr = RELOAD_PLAY;
         end
         res.diff_count = diff_acc;
         res.still_count = still_ctr;
         action_hits[res.action]++;
         pending_frames.push_back(res);
         pix_idx = 0;
         diff_acc = '0;
      end
   endfunction

   task automatic send_pixel(input bit pix, input bit last);
      int unsigned gap;
      if (gaps_on && burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (burst_left != 0)
         burst_left--;
      req_valid <= 1'b1;
      req_pixel_on <= pix;
      req_frame_end <= last;
      do @(posedge clock); while (!req_ready);
      score_pixel(pix, last);
      pixels_sent++;
   endtask

   task automatic send_frame(input int unsigned len, input frame_kind_type kind);
      int unsigned flip_pct;
      bit          pix;
      bit          old;
      flip_pct = $urandom_range(1, 30);
      for (int unsigned i = 0; i < len; i++) begin
         old = (i < PIX_TOTAL) ? prev_frame[i] : 1'b0;
         case (kind)
            FRAME_SAME:  pix = old;
            FRAME_FLIPS: pix = old ^ ($urandom_range(99) < flip_pct);
            FRAME_NOISE: pix = $urandom_range(1);
            FRAME_WHITE: pix = 1'b1;
            default:     pix = 1'b0;
         endcase
         send_pixel(pix, i == len - 1);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_frames.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // setup then access; leaves psel high so transfers can run back to back
   task automatic apb_transfer(input bit is_write, input logic [CSR_ADDR_W-1:0] addr,
                               input logic [CSR_DATA_W-1:0] wdata,
                               output logic [CSR_DATA_W-1:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= is_write;
      csr_paddr <= addr;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
   endtask

   task automatic csr_readback(input logic [CSR_ADDR_W-1:0] addr,
                               input logic [CSR_DATA_W-1:0] want, input int unsigned width);
      logic [CSR_DATA_W-1:0] mask;
      logic [CSR_DATA_W-1:0] got;
      mask = (32'd1 << width) - 32'd1;
      apb_transfer(1'b0, addr, '0, got);
      if ((got & mask) !== (want & mask)) begin
         $error("register at 0x%0h: expected 0x%0h, got 0x%0h", addr, want & mask, got & mask);
         fail_count++;
      end
   endtask

   task automatic csr_write_check(input logic [CSR_ADDR_W-1:0] addr,
                                  input int unsigned value, input int unsigned width);
      logic [CSR_DATA_W-1:0] mask;
      logic [CSR_DATA_W-1:0] data;
      logic [CSR_DATA_W-1:0] unused;
      mask = (32'd1 << width) - 32'd1;
      data = value & mask;
      // junk above the register width must be dropped
      if ($urandom_range(1))
         data |= $urandom() & ~mask;
      apb_transfer(1'b1, addr, data, unused);
      csr_writes++;
      if (addr == ADDR_RUN_MODE)
         cfg_mode = data[MODE_W-1:0];
      else
         cfg_thresh = data[ACC_W-1:0];
      csr_readback(addr, data, width);
   endtask

   task automatic set_config(input logic [MODE_W-1:0] mode, input int unsigned thresh);
      wait_idle();
      csr_write_check(ADDR_RUN_MODE, mode, MODE_W);
      csr_write_check(ADDR_THRESH, thresh, ACC_W);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // every mode reaching its trigger, zero and full-frame (PIX_TOTAL) thresholds
   task automatic test_directed();
      gaps_on = 1'b0;
      sink_style = SINK_ALWAYS;
      csr_readback(ADDR_RUN_MODE, '0, MODE_W);
      csr_readback(ADDR_THRESH, THRESH_RESET, ACC_W);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      send_pixel(1'b1, 1'b1);
      send_pixel(1'b0, 1'b1);
      send_pixel(1'b1, 1'b0);
      send_pixel(1'b1, 1'b0);
      send_pixel(1'b1, 1'b1);
      send_pixel(1'b1, 1'b0);
      send_pixel(1'b1, 1'b0);
      send_pixel(1'b1, 1'b1);
      // zero threshold: nothing counts as still
      set_config(MODE_LEARN, 0);
      send_pixel(1'b0, 1'b1);
      set_config(MODE_LEARN, PIX_TOTAL);
      repeat (4) send_pixel(1'b0, 1'b1);
      set_config(MODE_BOOT, 0);
      send_pixel(1'b1, 1'b1);
      set_config(MODE_BOOT, PIX_TOTAL);
      repeat (2) send_pixel(1'b1, 1'b1);
      set_config(MODE_PLAY_ALT, PIX_TOTAL);
      repeat (4) send_pixel(1'b1, 1'b1);
      wait_idle();
   endtask

   // a long noisy frame, then shorter frames over a partly stale store
   task automatic test_long_frame();
      set_config(MODE_PLAY, PIX_TOTAL);
      gaps_on = 1'b0;
      sink_style = SINK_RANDOM;
      sink_stall_pct = 40;
      send_frame(60, FRAME_NOISE);
      send_frame(20, FRAME_SAME);
      send_frame(40, FRAME_FLIPS);
      wait_idle();
   endtask

   // receiver holds off long enough for frame ends to back up into the input
   task automatic test_stalled_output();
      set_config(MODE_PLAY, 3);
      gaps_on = 1'b0;
      sink_style = SINK_ALWAYS;
      hold_request <= 1'b1;
      repeat (40) send_frame($urandom_range(1, 3), frame_kind_type'($urandom_range(4)));
      wait_idle();
      gaps_on = 1'b1;
      sink_style = SINK_PERIODIC;
      repeat (10) send_frame($urandom_range(1, 4), FRAME_SAME);
      wait_idle();
   endtask

   task automatic test_random_frames();
      int unsigned       start;
      int unsigned       len;
      int unsigned       pick;
      int unsigned       thresh;
      logic [MODE_W-1:0] mode;
      frame_kind_type    kind;
      for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
         mode = (p < 4) ? MODE_W'(p) : MODE_W'($urandom_range(3));
         case ($urandom_range(7))
            0:       thresh = 0;
            1:       thresh = PIX_TOTAL;
            2:       thresh = THRESH_RESET;
            3:       thresh = $urandom_range(0, PIX_TOTAL);
            4, 5:    thresh = $urandom_range(1, 6);
            default: thresh = $urandom_range(0, 24);
         endcase
         set_config(mode, thresh);
         // one phase runs flat out on both sides
         gaps_on = (p != 2);
         sink_style = (p == 2) ? SINK_ALWAYS : sink_style_type'($urandom_range(2));
         sink_stall_pct = $urandom_range(10, 70);
         start = pixels_sent;
         while (pixels_sent - start < PHASE_PIXELS) begin
            pick = $urandom_range(99);
            if (pick < 80)
               len = $urandom_range(1, 12);
            else if (pick < 98)
               len = $urandom_range(13, 40);
            else
               len = $urandom_range(41, 300);
            pick = $urandom_range(99);
            if (pick < 30)
               kind = FRAME_SAME;
            else if (pick < 65)
               kind = FRAME_FLIPS;
            else if (pick < 85)
               kind = FRAME_NOISE;
            else if (pick < 92)
               kind = FRAME_WHITE;
            else
               kind = FRAME_BLACK;
            send_frame(len, kind);
         end
      end
      wait_idle();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_long_frame();
      test_stalled_output();
      test_random_frames();
      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d pixels in %0d checked frames, %0d csr writes",
               pixels_sent, frames_checked, csr_writes);
      $display("frame actions: none %0d, learn %0d, classify %0d, bootstrap %0d",
               action_hits[ACT_NONE], action_hits[ACT_LEARN], action_hits[ACT_CLASSIFY],
               action_hits[ACT_BOOT]);
      if (fail_count == 0 && pending_frames.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
